// ===== rtl/abbc_pkg.sv =====
// Shared constants for the averaged beam-break counter.
package abbc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COUNT_LIMIT    = 2'd2;

    // Reset values of the registers
    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 12'd20;
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 12'd40;
    localparam logic [COUNT_W-1:0]  COUNT_LIMIT_RST    = 8'd2;

endpackage

// ===== rtl/abbc_detector.sv =====
// Boxcar average from the window sum, hysteresis detector and result register.
module abbc_detector
    import abbc_pkg::*;
#(
    parameter int WINDOW = 4
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic [$clog2(WINDOW*4095+1)-1:0]          sum,
    input  logic [SAMPLE_W-1:0]                       low_threshold,
    input  logic [SAMPLE_W-1:0]                       high_threshold,
    input  logic [COUNT_W-1:0]                        count_limit,
    output logic [SAMPLE_W-1:0]                       average,
    output logic [COUNT_W-1:0]                        break_count,
    output logic                                      limit_reached
);

    localparam int SUM_W   = $clog2(WINDOW*4095+1);
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Rounded-up reciprocal; exact floor division for every SUM_W-bit sum
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] avg;
    logic                hit;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                blocked_reg, blocked_next;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                limit_reg;

    assign product = PROD_W'(sum) * PROD_W'(RECIP);
    assign avg     = product[SHIFT +: SAMPLE_W];
    assign hit     = (avg <= low_threshold) && !blocked_reg;

    always_comb
    begin
        count_next = count_reg;
        if (hit && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
        end
        // re-arm test follows the break test and wins
        priority if (avg >= high_threshold)
        begin
            blocked_next = 1'b0;
        end
        else if (hit)
        begin
            blocked_next = 1'b1;
        end
        else
        begin
            blocked_next = blocked_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            blocked_reg <= 1'b1;
        end
        else if (en)
        begin
            count_reg   <= count_next;
            blocked_reg <= blocked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            avg_reg   <= avg;
            limit_reg <= (count_next >= count_limit);
        end
    end

    assign average       = avg_reg;
    assign break_count   = count_reg;
    assign limit_reached = limit_reg;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        en && hit && count_reg != COUNT_MAX |=> count_reg == $past(count_reg) + 1'b1)
        else $error("break count did not step on a detected break");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(count_reg) && $stable(blocked_reg))
        else $error("detector state changed without a word");

endmodule

// ===== rtl/averaged_beam_break_counter.sv =====
// Top level: sample window with running sum, detector stage and stream ports.
// Throughput: one word per cycle while results are taken; the window sum
// update and the reciprocal multiply plus compares each take one register stage.
// Back pressure only stalls the input when both stages hold a word and the
// output is not ready. Reset clears the window, sum, position and count, sets
// the blocked flag high and loads the default thresholds and limit.
module averaged_beam_break_counter
    import abbc_pkg::*;
#(
    parameter int WINDOW = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [11:0] sample, [15:12] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [11:0] average, [19:12] break_count,
                                                  // [20] limit_reached, [23:21] zero
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SUM_W = $clog2(WINDOW*4095+1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    logic [SAMPLE_W-1:0] low_reg, high_reg;
    logic [COUNT_W-1:0]  limit_reg;

    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PTR_W-1:0]    pos_reg, pos_next;
    logic                v1_reg;
    logic                out_valid_reg;

    logic                s2_ready, adv, accept;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]  break_count;
    logic                limit_reached;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= LOW_THRESHOLD_RST;
            high_reg  <= HIGH_THRESHOLD_RST;
            limit_reg <= COUNT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LOW_THRESHOLD:  low_reg   <= cfg_wdata;
                REG_HIGH_THRESHOLD: high_reg  <= cfg_wdata;
                REG_COUNT_LIMIT:    limit_reg <= cfg_wdata[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // handshake
    assign s2_ready      = !out_valid_reg || m_axis_tready;
    assign adv           = v1_reg && s2_ready;
    assign s_axis_tready = !v1_reg || s2_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // window update
    assign sample   = s_axis_tdata[SAMPLE_W-1:0];
    assign sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(sample);
    assign pos_next = (pos_reg == PTR_LAST) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg <= '0;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            ring_reg[pos_reg] <= sample;
            sum_reg           <= sum_next;
            pos_reg           <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv)
            begin
                v1_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    abbc_detector #(
        .WINDOW(WINDOW)
    ) u_detector (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .sum           (sum_reg),
        .low_threshold (low_reg),
        .high_threshold(high_reg),
        .count_limit   (limit_reg),
        .average       (average),
        .break_count   (break_count),
        .limit_reached (limit_reached)
    );

    assign m_axis_tdata = {3'b000, limit_reached, break_count, average};

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled with a free stage");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PTR_LAST)
        else $error("window position out of range");

    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced word did not reach the output");

endmodule
